FILE: sv/rc_packet_framer_crc16_defines.svh
// ---------------------------------------------------------------------------
// rc_packet_framer_crc16 assertion macros
// Short forms for clocked properties with the reset disable built in.
// ---------------------------------------------------------------------------
`ifndef RC_PACKET_FRAMER_CRC16_DEFINES_SVH
`define RC_PACKET_FRAMER_CRC16_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/rpf_pkg.sv
// ---------------------------------------------------------------------------
// rpf_pkg
// Shared types, constants and CRC helpers of the RC packet framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpf_pkg;

  localparam int unsigned CHANNEL_COUNT = 16;
  localparam int unsigned FRAME_LEN     = 30;

  typedef enum logic [2:0] {
    CMD_LOAD_CH  = 3'd0,
    CMD_LOAD_HOP = 3'd1,
    CMD_DATA     = 3'd2,
    CMD_BIND     = 3'd3,
    CMD_RESTART  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_TX_ID     = 3'd0,
    CFG_HOP_STEP  = 3'd1,
    CFG_OVR_EN    = 3'd2,
    CFG_THR_SAFE  = 3'd3,
    CFG_MID       = 3'd4,
    CFG_THR_CH    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOP,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  item_index;
    logic [11:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Override settings seen by the channel mapper
  typedef struct packed {
    logic        enable;
    logic [11:0] safe_val;
    logic [11:0] mid_val;
    logic [3:0]  thr_ch;
  } ovr_cfg_t;

  localparam logic [11:0] CH_MIN        = 12'd860;
  localparam logic [11:0] CH_MAX        = 12'd2172;
  localparam logic [10:0] CH_OFFSET     = 11'd64;
  localparam logic [11:0] CH_RESET_VAL  = 12'd1500;
  localparam logic [11:0] THR_RESET_VAL = 12'd988;
  localparam logic [3:0]  THR_RESET_IDX = 4'd2;

  localparam logic [7:0] SYNC_BYTE     = 8'h1D;
  localparam logic [7:0] DATA_TYPE     = 8'h02;
  localparam logic [7:0] BIND_TYPE     = 8'h03;
  localparam logic [7:0] ONE_BYTE      = 8'h01;
  localparam logic [7:0] DATA_TAIL     = 8'h08;

  localparam logic [3:0] FETCH_DATA_N  = 4'd8;
  localparam logic [3:0] FETCH_BIND_N  = 4'd5;

  localparam logic [15:0] CRC_NIB_MULT = 16'h1081;

  function automatic logic [15:0] crc_nib(input logic [3:0] n);
    logic [15:0] r;
    case (n)
      4'h0:    r = 16'h0000;
      4'h1:    r = 16'h1189;
      4'h2:    r = 16'h2312;
      4'h3:    r = 16'h329B;
      4'h4:    r = 16'h4624;
      4'h5:    r = 16'h57AD;
      4'h6:    r = 16'h6536;
      4'h7:    r = 16'h74BF;
      4'h8:    r = 16'h8C48;
      4'h9:    r = 16'h9DC1;
      4'hA:    r = 16'hAF5A;
      4'hB:    r = 16'hBED3;
      4'hC:    r = 16'hCA6C;
      4'hD:    r = 16'hDBE5;
      4'hE:    r = 16'hE97E;
      4'hF:    r = 16'hF8F7;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // One byte of the nibble-table CRC
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  v;
    logic [15:0] t;
    v = crc[15:8] ^ b;
    t = crc_nib(v[3:0]) ^ 16'(CRC_NIB_MULT * {12'd0, v[7:4]});
    return {crc[7:0], 8'h00} ^ t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rpf_ram.sv
// ---------------------------------------------------------------------------
// rpf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/rpf_chmap.sv
// ---------------------------------------------------------------------------
// rpf_chmap
// Channel mapper: override select, saturate, scale to the frame encoding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpf_chmap (
  input  wire logic             [11:0] value_i,
  input  wire logic             [3:0]  chan_i,
  input  wire logic                    upper_i,
  input  wire rpf_pkg::ovr_cfg_t       ovr_i,
  output logic                  [11:0] code_o
);
  import rpf_pkg::*;

  logic [11:0] sel;
  logic [11:0] sat;
  logic [10:0] diff;
  logic [11:0] triple;
  logic [10:0] scaled;

  always_comb begin
    sel = value_i;
    if (ovr_i.enable) begin
      sel = (chan_i == ovr_i.thr_ch) ? ovr_i.safe_val : ovr_i.mid_val;
    end
    if (sel < CH_MIN) begin
      sat = CH_MIN;
    end else if (sel > CH_MAX) begin
      sat = CH_MAX;
    end else begin
      sat = sel;
    end
    diff   = 11'(sat - CH_MIN);
    triple = {1'b0, diff} + {diff, 1'b0};
    scaled = triple[11:1] + CH_OFFSET;
    // upper half adds 2048; scaled value stays below 2048
    code_o = {upper_i, scaled};
  end

endmodule

`default_nettype wire

FILE: sv/rc_packet_framer_crc16.sv
// ---------------------------------------------------------------------------
// rc_packet_framer_crc16
// 30-byte frame builder for a 16-channel hopping RC link, CRC-16 trailer.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_* valid/ready channel. Load-channel,
//   load-hop, restart and unknown commands complete in the transfer cycle
//   and produce no output. Data and bind commands produce 30 output
//   transfers, one frame byte each, with last_byte set on the final byte.
//   Settings are to be written on the cfg_* port while the block is idle;
//   the block itself does not enforce this. Before the first byte of a
//   data frame is valid, its transfer is followed by hop position
//   reduction, the channel fetch and the load of the byte into the output
//   register; a bind frame skips the hop reduction.
//   Throughput: one frame at a time; with no stalls, the one-entry-per-cycle
//   fetch from the channel or hop memory is followed by one byte per cycle.
//   A receiver stall holds the output register and freezes the byte
//   sequencer; no byte is lost. A new command is taken while the last byte
//   of the previous frame still waits in the output register.
//   Reset sets the settings to their defaults, marks every memory entry as
//   unwritten (channels read 1500, channel 2 reads 988, hop entries read 0)
//   and clears hop position, half toggle and bind count. No clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc_packet_framer_crc16 #(
  parameter int unsigned HOP_TABLE_DEPTH = 64,
  parameter int unsigned HOP_MODULUS     = 47
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rpf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rpf_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);
  import rpf_pkg::*;

  localparam int unsigned AW = $clog2(HOP_TABLE_DEPTH);
  localparam logic [6:0]  HopMod = 7'(HOP_MODULUS);
  localparam logic [4:0]  LastIdx = 5'(FRAME_LEN - 1);

  // Settings
  logic [15:0] tx_id_q;
  logic [5:0]  hop_step_q;
  logic        ovr_en_q;
  logic [11:0] thr_safe_q;
  logic [11:0] mid_q;
  logic [3:0]  thr_ch_q;

  // Link state
  logic [6:0]  hop_pos_q;
  logic        half_tgl_q;
  logic [3:0]  bind_cnt_q;
  logic [CHANNEL_COUNT-1:0]   ch_vld_q;
  logic [HOP_TABLE_DEPTH-1:0] hop_vld_q;

  // Frame in progress
  state_e      state_q, state_d;
  logic        is_bind_q;
  logic        half_q;
  logic [5:0]  base_q;
  logic [3:0]  gcnt_q;
  logic [4:0]  cnt_q;
  logic [15:0] crc_q;
  logic [95:0] pl_q;
  logic [11:0] a_q;
  logic [3:0]  rd_ch_q;
  logic        rd_fresh_q;

  out_item_t   out_q;
  logic        ovalid_q;

  // FSM outputs
  logic        accept;
  logic        gen_load;
  logic        fetch_take;
  logic [3:0]  fetch_n;

  // Memory ports
  logic                ch_we;
  logic [3:0]          ch_raddr;
  logic [11:0]         ch_wdata;
  logic [11:0]         ch_rdata;
  logic                hop_we;
  logic [AW-1:0]       hop_waddr;
  logic [6:0]          hop_rsum;
  logic [AW-1:0]       hop_raddr;
  logic [7:0]          hop_rdata;

  // Datapath
  logic [11:0] ch_raw;
  logic [11:0] ch_code;
  ovr_cfg_t    ovr_cfg;
  logic [7:0]  hop_byte;
  logic [7:0]  frame_byte;
  logic        in_pay;
  logic        in_crc;
  logic [5:0]  bind_base;

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.cmd == CMD_DATA) begin
          state_d = ST_HOP;
        end else if (accept && in_data_i.cmd == CMD_BIND) begin
          state_d = ST_FETCH;
        end
      end
      ST_HOP: begin
        // reduce until the position lies below the modulus
        if (hop_pos_q < HopMod) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (gcnt_q == fetch_n) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (gen_load && cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: outputs
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    gen_load   = 1'b0;
    fetch_take = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_HOP:   in_ready_o = 1'b0;
      ST_FETCH: fetch_take = (gcnt_q != 4'd0);
      ST_SEND:  gen_load   = !ovalid_q || out_ready_i;
      default:  in_ready_o = 1'b0;
    endcase
  end

  assign accept  = in_valid_i && in_ready_o;
  assign fetch_n = is_bind_q ? FETCH_BIND_N : FETCH_DATA_N;

  // -------------------------------------------------------------------------
  // Channel and hop memories. Writes only happen in idle and read data is only
  // used while fetching, so a read that meets a write in one cycle is never used.
  // -------------------------------------------------------------------------
  assign ch_we    = accept && in_data_i.cmd == CMD_LOAD_CH
                    && 32'(in_data_i.item_index) < CHANNEL_COUNT;
  assign ch_wdata = (in_data_i.item_value < CH_MIN) ? CH_MIN :
                    (in_data_i.item_value > CH_MAX) ? CH_MAX : in_data_i.item_value;
  assign ch_raddr = {half_q, gcnt_q[2:0]};

  assign hop_we    = accept && in_data_i.cmd == CMD_LOAD_HOP
                     && 32'(in_data_i.item_index) < HOP_TABLE_DEPTH;
  assign hop_waddr = AW'(in_data_i.item_index);
  // bind entries stop at index 49, inside the default 64-entry table
  assign hop_rsum  = {1'b0, base_q} + {3'd0, gcnt_q};
  assign hop_raddr = AW'(hop_rsum);

  rpf_ram #(
    .WIDTH (12),
    .DEPTH (CHANNEL_COUNT)
  ) u_ch_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (in_data_i.item_index[3:0]),
    .wdata_i (ch_wdata),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  rpf_ram #(
    .WIDTH (8),
    .DEPTH (HOP_TABLE_DEPTH)
  ) u_hop_ram (
    .clk_i   (clk_i),
    .we_i    (hop_we),
    .waddr_i (hop_waddr),
    .wdata_i (in_data_i.item_value[7:0]),
    .raddr_i (hop_raddr),
    .rdata_o (hop_rdata)
  );

  // Unwritten entries read as their reset contents
  assign ch_raw   = rd_fresh_q ? ch_rdata :
                    (rd_ch_q == THR_RESET_IDX) ? THR_RESET_VAL : CH_RESET_VAL;
  assign hop_byte = rd_fresh_q ? hop_rdata : 8'h00;

  assign ovr_cfg = '{enable: ovr_en_q, safe_val: thr_safe_q, mid_val: mid_q,
                     thr_ch: thr_ch_q};

  rpf_chmap u_chmap (
    .value_i (ch_raw),
    .chan_i  (rd_ch_q),
    .upper_i (half_q),
    .ovr_i   (ovr_cfg),
    .code_o  (ch_code)
  );

  // -------------------------------------------------------------------------
  // Frame byte for the current position
  // -------------------------------------------------------------------------
  assign in_pay = is_bind_q ? (cnt_q >= 5'd6 && cnt_q <= 5'd10)
                            : (cnt_q >= 5'd9 && cnt_q <= 5'd20);
  assign in_crc = cnt_q >= 5'd3 && cnt_q <= 5'd27;

  always_comb begin
    frame_byte = 8'h00;
    if (in_pay) begin
      frame_byte = is_bind_q ? pl_q[39:32] : pl_q[95:88];
    end else if (is_bind_q) begin
      case (cnt_q)
        5'd0:    frame_byte = SYNC_BYTE;
        5'd1:    frame_byte = BIND_TYPE;
        5'd2:    frame_byte = ONE_BYTE;
        5'd3:    frame_byte = tx_id_q[15:8];
        5'd4:    frame_byte = tx_id_q[7:0];
        5'd5:    frame_byte = {2'b00, base_q};
        5'd11:   frame_byte = DATA_TYPE;
        5'd12:   frame_byte = ONE_BYTE;
        5'd28:   frame_byte = crc_q[15:8];
        5'd29:   frame_byte = crc_q[7:0];
        default: frame_byte = 8'h00;
      endcase
    end else begin
      case (cnt_q)
        5'd0:    frame_byte = SYNC_BYTE;
        5'd1:    frame_byte = tx_id_q[15:8];
        5'd2:    frame_byte = tx_id_q[7:0];
        5'd3:    frame_byte = DATA_TYPE;
        5'd4:    frame_byte = {hop_step_q[1:0], hop_pos_q[5:0]};
        5'd5:    frame_byte = {4'h0, hop_step_q[5:2]};
        5'd6:    frame_byte = ONE_BYTE;
        5'd21:   frame_byte = DATA_TAIL;
        5'd28:   frame_byte = crc_q[15:8];
        5'd29:   frame_byte = crc_q[7:0];
        default: frame_byte = 8'h00;
      endcase
    end
  end

  assign bind_base = 6'({bind_cnt_q, 2'b00}) + {2'b00, bind_cnt_q};

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tx_id_q    <= 16'd0;
      hop_step_q <= 6'd1;
      ovr_en_q   <= 1'b1;
      thr_safe_q <= THR_RESET_VAL;
      mid_q      <= CH_RESET_VAL;
      thr_ch_q   <= THR_RESET_IDX;
      hop_pos_q  <= 7'd0;
      half_tgl_q <= 1'b0;
      bind_cnt_q <= 4'd0;
      ch_vld_q   <= '0;
      hop_vld_q  <= '0;
      gcnt_q     <= 4'd0;
      cnt_q      <= 5'd0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TX_ID:    tx_id_q    <= cfg_data_i;
          CFG_HOP_STEP: hop_step_q <= cfg_data_i[5:0];
          CFG_OVR_EN:   ovr_en_q   <= cfg_data_i[0];
          CFG_THR_SAFE: thr_safe_q <= cfg_data_i[11:0];
          CFG_MID:      mid_q      <= cfg_data_i[11:0];
          CFG_THR_CH:   thr_ch_q   <= cfg_data_i[3:0];
          default:      ;
        endcase
      end

      if (ch_we) begin
        ch_vld_q[in_data_i.item_index[3:0]] <= 1'b1;
      end
      if (hop_we) begin
        hop_vld_q[hop_waddr] <= 1'b1;
      end

      // Advance the hop position, then reduce it in ST_HOP
      if (accept && in_data_i.cmd == CMD_DATA) begin
        hop_pos_q  <= hop_pos_q + {1'b0, hop_step_q};
        half_tgl_q <= ~half_tgl_q;
      end else if (accept && in_data_i.cmd == CMD_BIND) begin
        bind_cnt_q <= (bind_cnt_q == 4'd9) ? 4'd0 : bind_cnt_q + 4'd1;
      end else if (accept && in_data_i.cmd == CMD_RESTART) begin
        hop_pos_q  <= 7'd0;
        bind_cnt_q <= 4'd0;
      end else if (state_q == ST_HOP && hop_pos_q >= HopMod) begin
        hop_pos_q <= hop_pos_q - HopMod;
      end

      if (state_q == ST_FETCH) begin
        gcnt_q <= (gcnt_q == fetch_n) ? 4'd0 : gcnt_q + 4'd1;
      end

      if (gen_load) begin
        cnt_q <= (cnt_q == LastIdx) ? 5'd0 : cnt_q + 5'd1;
      end

      if (gen_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_bind_q <= in_data_i.cmd == CMD_BIND;
      half_q    <= half_tgl_q;
      base_q    <= bind_base;
      crc_q     <= 16'h0000;
    end

    // Track the entry and its written flag for the read in flight
    rd_ch_q    <= ch_raddr;
    rd_fresh_q <= is_bind_q ? hop_vld_q[hop_raddr] : ch_vld_q[ch_raddr];

    if (fetch_take) begin
      if (is_bind_q) begin
        pl_q <= {pl_q[87:0], hop_byte};
      end else if (!rd_ch_q[0]) begin
        a_q <= ch_code;
      end else begin
        // pack the pair as low byte of a, mixed nibbles, high byte of b
        pl_q <= {pl_q[71:0], a_q[7:0], ch_code[3:0], a_q[11:8], ch_code[11:4]};
      end
    end else if (gen_load && in_pay) begin
      pl_q <= {pl_q[87:0], 8'h00};
    end

    if (gen_load) begin
      out_q.out_byte  <= frame_byte;
      out_q.last_byte <= cnt_q == LastIdx;
      if (in_crc) begin
        crc_q <= crc_step(crc_q, frame_byte);
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/rpf_checker.sv
// ---------------------------------------------------------------------------
// rpf_checker
// Port-level checks of the RC packet framer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_packet_framer_crc16_defines.svh"

module rpf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire rpf_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire rpf_pkg::out_item_t out_data_i
);
  import rpf_pkg::*;

  logic in_xfer;
  logic emit_cmd;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign emit_cmd = in_data_i.cmd == CMD_DATA || in_data_i.cmd == CMD_BIND;

  // hold a stalled byte
  `RPF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled output byte changed")

  // a frame command blocks further input
  `RPF_ASSERT_NEXT(a_emit_busy, in_xfer && emit_cmd, !in_ready_i, "input open after frame command")

  // other commands keep the input ready in the next cycle
  `RPF_ASSERT_NEXT(a_load_idle, in_xfer && !emit_cmd, in_ready_i, "input closed after non-frame command")

  // a pending byte before the last one means the frame is still running
  `RPF_ASSERT_SAME(a_mid_frame, out_valid_i && !out_data_i.last_byte, !in_ready_i, "input open in mid-frame")

endmodule

bind rc_packet_framer_crc16 rpf_checker u_rpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
